// ===== hdl/cle_pkg.sv =====
package cle_pkg;

    localparam logic [31:0] WIN_LOW  = 32'ha000_0000;
    localparam logic [31:0] WIN_HIGH = 32'ha3ff_ffff;

    localparam logic [7:0] CH_EOT   = 8'd4;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DESC = 2'd1;
    localparam logic [1:0] ST_ADDR     = 2'd2;

    localparam int MAX_RES = 3;

    typedef struct packed {
        logic        req_type;
        logic [15:0] descriptor;
        logic [31:0] dest_address;
        logic [31:0] byte_limit;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        echo_valid;
        logic [7:0]  echo_byte;
        logic        store_valid;
        logic [31:0] store_offset;
        logic [7:0]  store_byte;
        logic        line_done;
        logic [31:0] line_length;
        logic [1:0]  status;
        logic        last;
    } result_t;

    // results of one item handed from the editor core to the result queue
    typedef struct packed {
        logic                      load;
        logic [1:0]                count;
        result_t [MAX_RES-1:0]     res;
    } res_load_t;

endpackage

// ===== hdl/console_line_editor.sv =====
// console line editor: canonical-mode line input for a serial console
// path: an accepted item sits in the input register until the core takes it; the core decodes
//   it combinationally and registers its results in the result queue, which drives m_
// throughput: one item per cycle for items with no result while the result queue has space;
//   an item with results (up to three) waits for space in the three-slot result queue
// reset: synchronous, active low; no line open, fill index and limit cleared
module console_line_editor (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // descriptor, dest_address, byte_limit, rx_byte
    input  logic        s_tuser,   // req_type
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // echo_valid, echo_byte, store_valid, store_offset,
                                   // store_byte, line_done, line_length, status, pad
    output logic        m_tlast    // last result of the input item
);
    import cle_pkg::*;

    // input register stage
    logic     in_valid_reg;
    in_item_t in_item_reg;
    in_item_t in_item_next;

    logic      take;
    logic      space;
    res_load_t ld;
    result_t   out_res;

    // unpack the stream word, first field in the low bits
    always_comb begin
        in_item_next.req_type     = s_tuser;
        in_item_next.descriptor   = s_tdata[15:0];
        in_item_next.dest_address = s_tdata[47:16];
        in_item_next.byte_limit   = s_tdata[79:48];
        in_item_next.rx_byte      = s_tdata[87:80];
    end

    // the register frees up in the same cycle the core consumes its item
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_next;
        end
    end

    // line state and per-item decode
    cle_line_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .space      (space),
        .take       (take),
        .ld         (ld)
    );

    // holds the up to three results of one item and plays them out in order
    cle_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ld        (ld),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // pack result fields, lowest first, zero pad to whole bytes
    assign m_tdata = {3'b000,
                      out_res.status,
                      out_res.line_length,
                      out_res.line_done,
                      out_res.store_byte,
                      out_res.store_offset,
                      out_res.store_valid,
                      out_res.echo_byte,
                      out_res.echo_valid};
    assign m_tlast = out_res.last;

endmodule

// ===== hdl/cle_line_core.sv =====
module cle_line_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  cle_pkg::in_item_t item,
    input  logic              space,
    output logic              take,
    output cle_pkg::res_load_t ld
);
    import cle_pkg::*;

    logic        line_open_reg, line_open_next;
    logic [31:0] fill_index_reg, fill_index_next;
    logic [31:0] limit_held_reg, limit_held_next;

    logic [31:0] fill_inc;
    logic [32:0] addr_end;
    logic [1:0]  n;
    result_t [MAX_RES-1:0] res;

    assign take     = item_valid && space;
    assign fill_inc = fill_index_reg + 32'd1;
    assign addr_end = {1'b0, item.dest_address} + {1'b0, item.byte_limit};

    always_comb begin
        line_open_next  = line_open_reg;
        fill_index_next = fill_index_reg;
        limit_held_next = limit_held_reg;
        res             = '0;
        n               = 2'd0;
        if (take) begin
            if (item.req_type == REQ_START) begin
                line_open_next  = 1'b0;
                fill_index_next = '0;
                priority if (item.descriptor != 16'd0) begin
                    res[0].line_done = 1'b1;
                    res[0].status    = ST_BAD_DESC;
                    n = 2'd1;
                end else if (item.dest_address < WIN_LOW ||
                             addr_end > {1'b0, WIN_HIGH}) begin
                    res[0].line_done = 1'b1;
                    res[0].status    = ST_ADDR;
                    n = 2'd1;
                end else if (item.byte_limit == 32'd0) begin
                    res[0].echo_valid = 1'b1;
                    res[0].echo_byte  = CH_LF;
                    res[0].line_done  = 1'b1;
                    n = 2'd1;
                end else begin
                    line_open_next  = 1'b1;
                    limit_held_next = item.byte_limit;
                end
            end else if (line_open_reg) begin
                priority if (item.rx_byte == CH_EOT) begin
                    res[0].line_done   = 1'b1;
                    res[0].line_length = fill_index_reg;
                    line_open_next     = 1'b0;
                    n = 2'd1;
                end else if (item.rx_byte == CH_BS || item.rx_byte == CH_DEL) begin
                    res[0].echo_valid = 1'b1;
                    res[0].echo_byte  = CH_BS;
                    if (fill_index_reg != 32'd0) begin
                        fill_index_next     = fill_index_reg - 32'd1;
                        res[0].store_valid  = 1'b1;
                        res[0].store_offset = fill_index_reg - 32'd1;
                    end
                    res[1].echo_valid = 1'b1;
                    res[1].echo_byte  = CH_SPACE;
                    res[2].echo_valid = 1'b1;
                    res[2].echo_byte  = CH_BS;
                    n = 2'd3;
                end else if (item.rx_byte == CH_LF || item.rx_byte == CH_CR) begin
                    res[0].echo_valid   = 1'b1;
                    res[0].echo_byte    = item.rx_byte;
                    res[0].store_valid  = 1'b1;
                    res[0].store_offset = fill_index_reg;
                    res[0].store_byte   = CH_LF;
                    res[1].echo_valid   = 1'b1;
                    res[1].echo_byte    = CH_LF;
                    res[1].line_done    = 1'b1;
                    res[1].line_length  = fill_inc;
                    fill_index_next     = fill_inc;
                    line_open_next      = 1'b0;
                    n = 2'd2;
                end else begin
                    res[0].echo_valid   = 1'b1;
                    res[0].echo_byte    = item.rx_byte;
                    res[0].store_valid  = 1'b1;
                    res[0].store_offset = fill_index_reg;
                    res[0].store_byte   = item.rx_byte;
                    fill_index_next     = fill_inc;
                    n = 2'd1;
                    if (fill_inc >= limit_held_reg) begin
                        res[1].echo_valid  = 1'b1;
                        res[1].echo_byte   = CH_LF;
                        res[1].line_done   = 1'b1;
                        res[1].line_length = fill_inc;
                        line_open_next     = 1'b0;
                        n = 2'd2;
                    end
                end
            end
        end
        unique case (n)
            2'd1:    res[0].last = 1'b1;
            2'd2:    res[1].last = 1'b1;
            2'd3:    res[2].last = 1'b1;
            default: ;
        endcase
    end

    assign ld.load  = take && (n != 2'd0);
    assign ld.count = n;
    assign ld.res   = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_open_reg  <= 1'b0;
            fill_index_reg <= '0;
            limit_held_reg <= '0;
        end else begin
            line_open_reg  <= line_open_next;
            fill_index_reg <= fill_index_next;
            limit_held_reg <= limit_held_next;
        end
    end

    // an open line always has room left below its limit
    a_open_room: assert property (@(posedge aclk) disable iff (!aresetn)
        line_open_reg |-> (fill_index_reg < limit_held_reg))
        else $error("open line at or beyond its limit");

    // a start item never leaves more than one result
    a_start_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && item.req_type == REQ_START) |-> (n == 2'd0 || n == 2'd1))
        else $error("start item produced several results");

endmodule

// ===== hdl/cle_result_queue.sv =====
module cle_result_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  cle_pkg::res_load_t ld,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output cle_pkg::result_t   out_res
);
    import cle_pkg::*;

    result_t    res_reg [MAX_RES];
    logic [1:0] rd_idx_reg;
    logic [1:0] cnt_reg;
    logic       fire;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = res_reg[rd_idx_reg];
    assign fire      = out_valid && out_ready;
    assign space     = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_ff @(posedge aclk) begin
        if (ld.load) begin
            for (int i = 0; i < MAX_RES; i++) begin
                res_reg[i] <= ld.res[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            cnt_reg    <= '0;
        end else if (ld.load) begin
            rd_idx_reg <= '0;
            cnt_reg    <= ld.count;
        end else if (fire) begin
            rd_idx_reg <= rd_idx_reg + 2'd1;
            cnt_reg    <= cnt_reg - 2'd1;
        end
    end

    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_res.last) |-> (cnt_reg == 2'd1))
        else $error("last flag on a result that is not the final one");

    a_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_res.last) |-> (cnt_reg > 2'd1))
        else $error("final result of an item lacks the last flag");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        ld.load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && fire)))
        else $error("results loaded over undelivered ones");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, rd_idx_reg} + {1'b0, cnt_reg}) <= 3'd3)
        else $error("read index runs past loaded results");

endmodule
